// ===== hw/rtl/sscs_pkg.sv =====
package sscs_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int BYTE_BITS   = 8;
    localparam int FRAME_BITS  = FRAME_BYTES * BYTE_BITS;
    localparam int BIT_CNT_W   = $clog2(FRAME_BITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] HEX_COUNT = 8'd16;
    localparam logic [7:0] SYM_BASE  = 8'd100;
    localparam logic [7:0] SYM_COUNT = 8'd12;
    localparam logic [7:0] SEG_BLANK = 8'h00;

    // segment bytes, a in bit 7 down to the point in bit 0
    localparam logic [7:0] HEX_SEG [16] = '{
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
        8'hFE, 8'hF6, 8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E
    };

    localparam logic [7:0] SYM_SEG [12] = '{
        8'h00, 8'hEE, 8'h7A, 8'h02, 8'h9C, 8'hC6,
        8'h3A, 8'hEC, 8'h10, 8'h12, 8'h92, 8'h80
    };

    typedef logic [FRAME_BITS-1:0] t_word;

    typedef struct packed {
        logic [7:0] left_char_one;
        logic [7:0] left_char_two;
        logic       left_point_one;
        logic       left_point_two;
        logic [7:0] left_char_three;
        logic [7:0] left_char_four;
        logic [7:0] right_char_one;
        logic [7:0] right_char_two;
        logic       right_point_one;
        logic       right_point_two;
        logic [7:0] right_char_three;
        logic [7:0] right_char_four;
    } t_frame;

    typedef struct packed {
        logic serial_bit;
        logic latch_now;
    } t_bit;

    // queue write side and read side
    typedef struct packed {
        logic  valid;
        t_word word;
    } t_q_beat;

    function automatic logic [7:0] seg_of(input logic [7:0] code, input logic point);
        logic [7:0] off;
        logic [7:0] seg;
        off = code - SYM_BASE;
        if (code < HEX_COUNT) begin
            seg = HEX_SEG[code[3:0]];
        end else if (off < SYM_COUNT) begin
            seg = SYM_SEG[off[3:0]];
        end else begin
            seg = SEG_BLANK;
        end
        return {seg[7:1], seg[0] | point};
    endfunction

endpackage

// ===== hw/rtl/sscs_if.sv =====
interface sscs_in_if;
    logic            valid;
    logic            ready;
    sscs_pkg::t_frame data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sscs_out_if;
    logic          valid;
    logic          ready;
    sscs_pkg::t_bit data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/seven_segment_chain_serializer.sv =====
// Channel   Dir  Beat                              Handshake
// i_frame   in   8 character codes, 4 point flags  valid/ready
// o_bits    out  serial_bit, latch_now             valid/ready
//
// One frame gives 64 output beats, one bit per cycle while o_bits.ready is
// high; the bit shifter in the back end sets that figure, and a queued frame
// follows the latch beat with no gap. From its input beat a frame passes the
// front register, the queue and the shifter before its first output bit.
// Reset is synchronous, active low, and clears only control state.
// The front register and a 2-entry queue let the input side keep taking
// frames while the output side is stalled.
module seven_segment_chain_serializer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sscs_in_if.sink     i_frame,
    sscs_out_if.source  o_bits
);

    sscs_pkg::t_q_beat w_wr;
    sscs_pkg::t_q_beat w_rd;
    logic              w_wr_ready;
    logic              w_pop;

    // front: look up segment bytes and hold the packed frame word
    sscs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_frame    (i_frame),
        .o_wr       (w_wr),
        .i_wr_ready (w_wr_ready)
    );

    // queue: decouple the lookup from the shifter
    sscs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_wr),
        .o_wr_ready (w_wr_ready),
        .o_rd       (w_rd),
        .i_pop      (w_pop)
    );

    // back: shift each word out low bit first, flag the last bit
    sscs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (w_rd),
        .o_pop   (w_pop),
        .o_bits  (o_bits)
    );

`ifndef ASSERT_OFF
    // hold a stalled frame word at the queue input
    a_wr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr.valid && !w_wr_ready) |=> (w_wr.valid && $stable(w_wr.word)))
        else $error("front word changed while stalled");

    // start the next frame right after a latch beat when one is queued
    a_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bits.valid && o_bits.ready && o_bits.data.latch_now && w_rd.valid)
        |=> (o_bits.valid && !o_bits.data.latch_now))
        else $error("gap or bad latch between queued frames");

    // load an idle shifter as soon as the queue holds a word
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_bits.valid && w_rd.valid) |=> o_bits.valid)
        else $error("shifter idle with frame queued");
`endif

endmodule

// ===== hw/rtl/sscs_front.sv =====
module sscs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sscs_in_if.sink            i_frame,
    output sscs_pkg::t_q_beat  o_wr,
    input  logic               i_wr_ready
);

    logic            r_vld;
    sscs_pkg::t_word r_word;
    sscs_pkg::t_word n_word;
    logic            w_take;

    assign i_frame.ready = !r_vld || i_wr_ready;
    assign w_take        = i_frame.valid && i_frame.ready;

    // pack bytes in send order, first byte in the low bits
    always_comb begin
        n_word[7:0]   = sscs_pkg::seg_of(i_frame.data.right_char_one, 1'b0);
        n_word[15:8]  = sscs_pkg::seg_of(i_frame.data.right_char_two,
                                         i_frame.data.right_point_one);
        n_word[23:16] = sscs_pkg::seg_of(i_frame.data.right_char_three,
                                         i_frame.data.right_point_two);
        n_word[31:24] = sscs_pkg::seg_of(i_frame.data.right_char_four, 1'b0);
        n_word[39:32] = sscs_pkg::seg_of(i_frame.data.left_char_four, 1'b0);
        n_word[47:40] = sscs_pkg::seg_of(i_frame.data.left_char_three,
                                         i_frame.data.left_point_two);
        n_word[55:48] = sscs_pkg::seg_of(i_frame.data.left_char_two,
                                         i_frame.data.left_point_one);
        n_word[63:56] = sscs_pkg::seg_of(i_frame.data.left_char_one, 1'b0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end else if (i_wr_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_word <= n_word;
        end
    end

    assign o_wr.valid = r_vld;
    assign o_wr.word  = r_word;

endmodule

// ===== hw/rtl/sscs_queue.sv =====
module sscs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sscs_pkg::t_q_beat i_wr,
    output logic              o_wr_ready,
    output sscs_pkg::t_q_beat o_rd,
    input  logic              i_pop
);

    localparam int PW = sscs_pkg::Q_PTR_W;
    localparam int CW = sscs_pkg::Q_CNT_W;

    sscs_pkg::t_word r_mem [sscs_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_wr_ready = (r_cnt != CW'(sscs_pkg::QUEUE_DEPTH));
    assign w_push     = i_wr.valid && o_wr_ready;
    assign w_pop      = i_pop && (r_cnt != '0);

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        if (p == PW'(sscs_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= bump(r_wp);
            end
            if (w_pop) begin
                r_rp <= bump(r_rp);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_wr.word;
        end
    end

    assign o_rd.valid = (r_cnt != '0);
    assign o_rd.word  = r_mem[r_rp];

endmodule

// ===== hw/rtl/sscs_back.sv =====
module sscs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sscs_pkg::t_q_beat i_rd,
    output logic              o_pop,
    sscs_out_if.source        o_bits
);

    localparam int CW = sscs_pkg::BIT_CNT_W;

    logic            r_busy;
    logic [CW-1:0]   r_cnt;
    sscs_pkg::t_word r_shift;
    logic            w_last;
    logic            w_take;

    assign w_last = (r_cnt == CW'(sscs_pkg::FRAME_BITS - 1));
    assign w_take = o_bits.valid && o_bits.ready;
    assign o_pop  = i_rd.valid && (!r_busy || (w_take && w_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (w_take) begin
            r_cnt <= r_cnt + 1'b1;
            if (w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_shift <= i_rd.word;
        end else if (w_take) begin
            r_shift <= r_shift >> 1;
        end
    end

    assign o_bits.valid           = r_busy;
    assign o_bits.data.serial_bit = r_shift[0];
    assign o_bits.data.latch_now  = w_last;

endmodule
